// ===== hdl/md5_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, initial chaining values and round tables of the MD5 unit.
// ----------------------------------------------------------------------------
package md5_pkg;

   // chaining word initial values
   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   // block queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // one 512-bit block, with a flag for the last block of a message
   typedef struct packed {
      logic              last_blk;
      logic [15:0][31:0] words;
   } blk_type;

   // per-step additive constants (sine table)
   function automatic logic [31:0] round_const(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0:  k = 32'hd76aa478;
         6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;
         6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;
         6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;
         6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;
         6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;
         6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;
         6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;
         6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;
         6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;
         6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;
         6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;
         6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;
         6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;
         6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;
         6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;
         6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;
         6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;
         6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;
         6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423d7;
         6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;
         6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;
         6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;
         6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;
         6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;
         6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   // left rotate amount by round and step within a group of four
   function automatic logic [4:0] rot_amt(input logic [1:0] rnd, input logic [1:0] j);
      logic [4:0] s;
      case ({rnd, j})
         4'd0:  s = 5'd7;
         4'd1:  s = 5'd12;
         4'd2:  s = 5'd17;
         4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;
         4'd5:  s = 5'd9;
         4'd6:  s = 5'd14;
         4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;
         4'd9:  s = 5'd11;
         4'd10: s = 5'd16;
         4'd11: s = 5'd23;
         4'd12: s = 5'd6;
         4'd13: s = 5'd10;
         4'd14: s = 5'd15;
         4'd15: s = 5'd21;
         default: s = 5'd7;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/md5_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// md5_front
// Gathers message bytes into 512-bit blocks, appends the end-of-message
// padding and bit length, and pushes finished blocks to the queue.
// ----------------------------------------------------------------------------
module md5_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire  [7:0]             req_tdata,   // [7:0] data_byte
   input  wire                    req_tuser,   // [0] byte_valid
   input  wire                    req_tlast,   // end_of_message
   output logic                   push_valid,
   input  wire                    push_ready,
   output md5_pkg::blk_type       push_blk
);
   import md5_pkg::*;

   typedef enum logic [3:0] {
      F_ACCEPT = 4'b0001,
      F_MARK   = 4'b0010,
      F_ZERO   = 4'b0100,
      F_PUSH   = 4'b1000
   } fr_state_type;

   typedef enum logic [2:0] {
      AFT_ACCEPT = 3'b001,
      AFT_MARK   = 3'b010,
      AFT_ZERO2  = 3'b100
   } after_type;

   fr_state_type      st_ff, st_in;
   after_type         after_ff, after_in;
   logic [60:0]       cnt_ff, cnt_in;
   logic [15:0][31:0] blk_ff, blk_in;
   logic [3:0]        zw_ff, zw_in;
   logic              len_blk_ff, len_blk_in;
   logic              last_ff, last_in;

   logic              acc;
   logic [5:0]        pos;
   logic [31:0]       mark_word;
   logic [31:0]       zero_word;

   assign acc        = req_tvalid & req_tready;
   assign pos        = cnt_ff[5:0];
   assign req_tready = (st_ff == F_ACCEPT);
   assign push_valid = (st_ff == F_PUSH);
   assign push_blk   = '{last_blk: last_ff, words: blk_ff};

   // word holding the 0x80 marker: earlier bytes kept, later bytes cleared
   always_comb begin
      mark_word = blk_ff[pos[5:2]];
      for (int k = 0; k < 4; k++) begin
         if (2'(k) == pos[1:0]) begin
            mark_word[k*8 +: 8] = 8'h80;
         end else if (2'(k) > pos[1:0]) begin
            mark_word[k*8 +: 8] = 8'h00;
         end
      end
   end

   // fill word, bit length in the last two words of the length block
   always_comb begin
      zero_word = 32'h0;
      if (len_blk_ff && zw_ff == 4'd14) begin
         zero_word = {cnt_ff[28:0], 3'b000};
      end else if (len_blk_ff && zw_ff == 4'd15) begin
         zero_word = cnt_ff[60:29];
      end
   end

   // block assembly and padding sequencer
   always_comb begin
      st_in      = st_ff;
      after_in   = after_ff;
      cnt_in     = cnt_ff;
      blk_in     = blk_ff;
      zw_in      = zw_ff;
      len_blk_in = len_blk_ff;
      last_in    = last_ff;
      case (st_ff)
         F_ACCEPT: begin
            if (acc) begin
               if (req_tuser) begin
                  blk_in[pos[5:2]][{pos[1:0], 3'b000} +: 8] = req_tdata;
                  cnt_in = cnt_ff + 61'd1;
               end
               if (req_tuser && pos == 6'd63) begin
                  st_in    = F_PUSH;
                  last_in  = 1'b0;
                  after_in = req_tlast ? AFT_MARK : AFT_ACCEPT;
               end else if (req_tlast) begin
                  st_in = F_MARK;
               end
            end
         end
         F_MARK: begin
            blk_in[pos[5:2]] = mark_word;
            if (pos[5:2] == 4'd15) begin
               st_in    = F_PUSH;
               last_in  = 1'b0;
               after_in = AFT_ZERO2;
            end else begin
               st_in      = F_ZERO;
               zw_in      = pos[5:2] + 4'd1;
               len_blk_in = (pos[5:2] < 4'd14);
            end
         end
         F_ZERO: begin
            blk_in[zw_ff] = zero_word;
            if (zw_ff == 4'd15) begin
               st_in    = F_PUSH;
               last_in  = len_blk_ff;
               after_in = len_blk_ff ? AFT_ACCEPT : AFT_ZERO2;
            end else begin
               zw_in = zw_ff + 4'd1;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               if (last_ff) begin
                  cnt_in = 61'd0;
               end
               case (after_ff)
                  AFT_MARK: st_in = F_MARK;
                  AFT_ZERO2: begin
                     st_in      = F_ZERO;
                     zw_in      = 4'd0;
                     len_blk_in = 1'b1;
                  end
                  default: st_in = F_ACCEPT;
               endcase
            end
         end
         default: st_in = F_ACCEPT;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= F_ACCEPT;
         after_ff   <= AFT_ACCEPT;
         cnt_ff     <= 61'd0;
         zw_ff      <= 4'd0;
         len_blk_ff <= 1'b0;
         last_ff    <= 1'b0;
      end else begin
         st_ff      <= st_in;
         after_ff   <= after_in;
         cnt_ff     <= cnt_in;
         zw_ff      <= zw_in;
         len_blk_ff <= len_blk_in;
         last_ff    <= last_in;
      end
   end

   // block buffer
   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

endmodule
`default_nettype wire

// ===== hdl/md5_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// md5_queue
// Short block queue that lets the front fill a block while the back
// compresses the one before.
// ----------------------------------------------------------------------------
module md5_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               push_valid,
   output logic              push_ready,
   input  md5_pkg::blk_type  push_blk,
   output logic              pop_valid,
   input  wire               pop_ready,
   output md5_pkg::blk_type  pop_blk
);
   import md5_pkg::*;

   blk_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                     do_push;
   logic                     do_pop;

   assign push_ready = (cnt_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_blk    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_blk;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/md5_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// md5_back
// Iterative MD5 compression, one step per cycle, with feed-forward into
// the chaining words and a registered digest output.
// ----------------------------------------------------------------------------
module md5_back (
   input  wire               clock,
   input  wire               reset,
   input  wire               pop_valid,
   output logic              pop_ready,
   input  md5_pkg::blk_type  pop_blk,
   output logic              busy,
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output logic [127:0]      rsp_tdata
);
   import md5_pkg::*;

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_RUN  = 4'b0010,
      B_ADD  = 4'b0100,
      B_OUT  = 4'b1000
   } bk_state_type;

   bk_state_type      st_ff, st_in;
   logic [15:0][31:0] msg_ff, msg_in;
   logic              last_ff, last_in;
   logic [5:0]        step_ff, step_in;
   logic [3:0][31:0]  wk_ff, wk_in;
   logic [3:0][31:0]  ch_ff, ch_in;
   logic              out_vld_ff, out_vld_in;
   logic [127:0]      out_dat_ff, out_dat_in;

   logic [1:0]        rnd;
   logic [3:0]        idx;
   logic [31:0]       fval;
   logic [3:0]        gsel;
   logic [31:0]       tsum;
   logic [63:0]       rot_wide;
   logic [31:0]       new_b;

   assign pop_ready  = (st_ff == B_IDLE);
   assign busy       = (st_ff != B_IDLE);
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_dat_ff;

   assign rnd = step_ff[5:4];
   assign idx = step_ff[3:0];

   // round function and message word select
   always_comb begin
      case (rnd)
         2'd0: begin
            fval = (wk_ff[1] & wk_ff[2]) | (~wk_ff[1] & wk_ff[3]);
            gsel = idx;
         end
         2'd1: begin
            fval = (wk_ff[1] & wk_ff[3]) | (wk_ff[2] & ~wk_ff[3]);
            gsel = 4'(idx * 4'd5 + 4'd1);
         end
         2'd2: begin
            fval = wk_ff[1] ^ wk_ff[2] ^ wk_ff[3];
            gsel = 4'(idx * 4'd3 + 4'd5);
         end
         default: begin
            fval = wk_ff[2] ^ (wk_ff[1] | ~wk_ff[3]);
            gsel = 4'(idx * 4'd7);
         end
      endcase
   end

   // one compression step
   assign tsum     = wk_ff[0] + fval + msg_ff[gsel] + round_const(step_ff);
   assign rot_wide = {tsum, tsum} << rot_amt(rnd, idx[1:0]);
   assign new_b    = wk_ff[1] + rot_wide[63:32];

   // step sequencer, feed-forward and output
   always_comb begin
      st_in      = st_ff;
      msg_in     = msg_ff;
      last_in    = last_ff;
      step_in    = step_ff;
      wk_in      = wk_ff;
      ch_in      = ch_ff;
      out_dat_in = out_dat_ff;
      out_vld_in = out_vld_ff;
      if (out_vld_ff && rsp_tready) begin
         out_vld_in = 1'b0;
      end
      case (st_ff)
         B_IDLE: begin
            if (pop_valid) begin
               msg_in  = pop_blk.words;
               last_in = pop_blk.last_blk;
               wk_in   = ch_ff;
               step_in = 6'd0;
               st_in   = B_RUN;
            end
         end
         B_RUN: begin
            wk_in[0] = wk_ff[3];
            wk_in[1] = new_b;
            wk_in[2] = wk_ff[1];
            wk_in[3] = wk_ff[2];
            step_in  = step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               st_in = B_ADD;
            end
         end
         B_ADD: begin
            for (int k = 0; k < 4; k++) begin
               ch_in[k] = ch_ff[k] + wk_ff[k];
            end
            st_in = last_ff ? B_OUT : B_IDLE;
         end
         B_OUT: begin
            if (!out_vld_ff) begin
               out_dat_in = {ch_ff[3], ch_ff[2], ch_ff[1], ch_ff[0]};
               out_vld_in = 1'b1;
               ch_in      = {INIT_D, INIT_C, INIT_B, INIT_A};
               st_in      = B_IDLE;
            end
         end
         default: st_in = B_IDLE;
      endcase
   end

   // control and chaining registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= B_IDLE;
         step_ff    <= 6'd0;
         last_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
         wk_ff      <= '0;
         ch_ff      <= {INIT_D, INIT_C, INIT_B, INIT_A};
      end else begin
         st_ff      <= st_in;
         step_ff    <= step_in;
         last_ff    <= last_in;
         out_vld_ff <= out_vld_in;
         wk_ff      <= wk_in;
         ch_ff      <= ch_in;
      end
   end

   // message block and digest payload
   always_ff @(posedge clock) begin
      msg_ff     <= msg_in;
      out_dat_ff <= out_dat_in;
   end

endmodule
`default_nettype wire

// ===== hdl/md5_message_digest_unit.sv =====
// Sequence: end of message takes a marker step, zero fills to the end of the block and a push;
//   a block takes a load, 64 steps and a feed-forward step, and the digest is then registered
//   in the output state once the last digest is taken; a spilled length adds a push, a block of fills and a block.
// Throughput: one byte per cycle inside a block; the sustained rate is set by
//   the one-step-per-cycle compression in the back end.
// Reset: synchronous; clears control and loads the MD5 initial chain words.
`default_nettype none
// ----------------------------------------------------------------------------
// md5_message_digest_unit
// Byte-stream MD5 hasher: front end builds and pads blocks, a short queue
// decouples it from the iterative compression back end.
// ----------------------------------------------------------------------------
module md5_message_digest_unit (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,   // [7:0] data_byte
   input  wire          req_tuser,   // [0] byte_valid
   input  wire          req_tlast,   // end_of_message
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [127:0] rsp_tdata    // [31:0] digest_a, [63:32] digest_b,
                                     // [95:64] digest_c, [127:96] digest_d
);
   import md5_pkg::*;

   logic    q_push_vld;
   logic    q_push_rdy;
   blk_type q_push_blk;
   logic    q_pop_vld;
   logic    q_pop_rdy;
   blk_type q_pop_blk;
   logic    bk_busy;

   // block builder and padding
   md5_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push_valid (q_push_vld),
      .push_ready (q_push_rdy),
      .push_blk   (q_push_blk)
   );

   // block queue
   md5_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_vld),
      .push_ready (q_push_rdy),
      .push_blk   (q_push_blk),
      .pop_valid  (q_pop_vld),
      .pop_ready  (q_pop_rdy),
      .pop_blk    (q_pop_blk)
   );

   // compression engine
   md5_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (q_pop_vld),
      .pop_ready  (q_pop_rdy),
      .pop_blk    (q_pop_blk),
      .busy       (bk_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   // end of message always leads into padding, so input stalls next cycle
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input not stalled after end of message");

   // a block waiting on a full queue stays offered
   a_push_held: assert property (@(posedge clock) disable iff (reset)
      q_push_vld && !q_push_rdy |=> q_push_vld)
      else $error("block dropped while queue full");

   // a block taken from the queue starts compression
   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      q_pop_vld && q_pop_rdy |=> bk_busy)
      else $error("popped block not compressed");
`endif

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the byte-stream MD5 unit. A queue of message items (bytes, idle
// items, message ends) feeds a stream driver with random gaps. A software
// MD5 runs on every accepted item, and each digest on rsp is compared word
// by word with the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench;

   typedef logic [3:0][31:0] digest_type;   // [0] digest_a .. [3] digest_d

   typedef struct packed {
      logic [7:0] data;
      logic       byte_valid;
      logic       end_msg;
      logic       drain_first;           // hold until all digests are back
   } msg_item_type;

   localparam int CYCLE_LIMIT = 600000;
   localparam int TAIL_CYCLES = 300;

   // md5 additive constants, one per step
   localparam logic [31:0] SINE_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423d7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // rotate amounts by round and step within a group of four
   localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                   4, 11, 16, 23, 6, 10, 15, 21};

   localparam digest_type MD5_IV = {32'h10325476, 32'h98badcfe,
                                    32'hefcdab89, 32'h67452301};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;    // [7:0] data_byte
   logic         req_tuser = 1'b0;     // [0] byte_valid
   logic         req_tlast = 1'b0;     // end_of_message
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;            // [31:0] digest_a, [63:32] digest_b,
                                       // [95:64] digest_c, [127:96] digest_d

   md5_message_digest_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   msg_item_type pending_items[$];
   digest_type   digest_queue[$];
   int           errors = 0;
   int           cycles = 0;
   logic         quiet = 1'b0;          // stretch with no idling on either side
   int           send_gap = 0;
   int           stall_left = 0;
   int           stim_items = 0;

   // software digest state
   digest_type  chain_state = MD5_IV;
   logic [31:0] msg_block [16];
   logic [60:0] msg_bytes = '0;

   // gap length: mostly short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   // one 64-step compression of msg_block into chain_state
   task automatic md5_compress();
      logic [31:0] a, b, c, d, f, t;
      int g, rnd, i, s;
      a = chain_state[0];
      b = chain_state[1];
      c = chain_state[2];
      d = chain_state[3];
      for (int n = 0; n < 64; n++) begin
         rnd = n / 16;
         i = n % 16;
         case (rnd)
            0: begin
               f = (b & c) | (~b & d);
               g = i;
            end
            1: begin
               f = (b & d) | (c & ~d);
               g = (5 * i + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * i + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * i) % 16;
            end
         endcase
         t = a + f + msg_block[g] + SINE_K[n];
         s = ROT_AMT[rnd * 4 + i % 4];
         a = d;
         d = c;
         c = b;
         b = b + ((t << s) | (t >> (32 - s)));
      end
      chain_state[0] += a;
      chain_state[1] += b;
      chain_state[2] += c;
      chain_state[3] += d;
   endtask

   task automatic put_block_byte(input int pos, input logic [7:0] value);
      msg_block[pos / 4][(pos % 4) * 8 +: 8] = value;
   endtask

   // absorb one accepted item; on a message end, pad and return the digest
   task automatic md5_absorb(input logic [7:0] data, input logic byte_valid,
                             input logic end_msg, output logic done,
                             output digest_type digest);
      int pos;
      logic [63:0] bit_len;
      done = 1'b0;
      digest = '0;
      if (byte_valid) begin
         pos = int'(msg_bytes[5:0]);
         put_block_byte(pos, data);
         msg_bytes = msg_bytes + 1'b1;
         if (pos == 63)
            md5_compress();
      end
      if (end_msg) begin
         pos = int'(msg_bytes[5:0]);
         put_block_byte(pos, 8'h80);
         for (int p = pos + 1; p < 64; p++)
            put_block_byte(p, 8'h00);
         // no room left for the length: spill into an extra block
         if (pos >= 56) begin
            md5_compress();
            for (int w = 0; w < 16; w++)
               msg_block[w] = '0;
         end
         bit_len = {msg_bytes, 3'b000};
         msg_block[14] = bit_len[31:0];
         msg_block[15] = bit_len[63:32];
         md5_compress();
         digest = chain_state;
         done = 1'b1;
         chain_state = MD5_IV;
         msg_bytes = '0;
      end
   endtask

   task automatic add_item(input logic [7:0] data, input logic byte_valid,
                           input logic end_msg, input logic drain_first);
      msg_item_type it;
      it.data = data;
      it.byte_valid = byte_valid;
      it.end_msg = end_msg;
      it.drain_first = drain_first;
      pending_items.push_back(it);
      stim_items++;
   endtask

   // a message of len bytes with random content and idle items mixed in
   task automatic add_message(input int len, input logic drain_first);
      logic [7:0] data;
      logic       end_on_byte;
      int r;
      end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 11) == 0)
            add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
         r = $urandom_range(0, 9);
         data = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom_range(0, 255));
         add_item(data, 1'b1, end_on_byte && (k == len - 1),
                  drain_first && (k == 0));
      end
      if (!end_on_byte)
         add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, drain_first && (len == 0));
   endtask

   // driver: predicts each accepted item, then offers the next one
   always @(posedge clock) begin : driver
      msg_item_type nxt;
      logic         offer;
      logic         done;
      digest_type   digest;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            md5_absorb(req_tdata, req_tuser, req_tlast, done, digest);
            if (done)
               digest_queue.push_back(digest);
            offer = 1'b0;
         end
         if (!offer) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].drain_first && digest_queue.size() != 0)) begin
               nxt = pending_items.pop_front();
               req_tdata <= nxt.data;
               req_tuser <= nxt.byte_valid;
               req_tlast <= nxt.end_msg;
               offer = 1'b1;
               send_gap <= pick_gap();
            end
         end
         req_tvalid <= offer;
      end
   end

   // monitor: compare each digest with the oldest prediction
   always @(posedge clock) begin : monitor
      digest_type got;
      digest_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (digest_queue.size() == 0) begin
               $display("%0t: unexpected digest, expected none, got %h", $time, got);
               errors++;
            end else begin
               want = digest_queue.pop_front();
               for (int k = 0; k < 4; k++) begin
                  if (got[k] !== want[k]) begin
                     $display("%0t: digest word %0d mismatch, expected %h, got %h",
                              $time, k, want[k], got[k]);
                     errors++;
                  end
               end
            end
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
         end
      end
   end

   // run limit and switching of quiet stretches
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles % 250 == 0)
         quiet <= ($urandom_range(0, 3) == 0);
      if (cycles >= CYCLE_LIMIT) begin
         $display("[md5_message_digest_unit] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int r;
      int len;
      // directed: empty message, idle item, "abc", single bytes, end without byte
      add_item(8'h5a, 1'b0, 1'b1, 1'b0);
      add_item(8'hff, 1'b0, 1'b0, 1'b0);
      add_item(8'h61, 1'b1, 1'b0, 1'b1);
      add_item(8'h62, 1'b1, 1'b0, 1'b0);
      add_item(8'h63, 1'b1, 1'b1, 1'b0);
      add_item(8'hff, 1'b1, 1'b1, 1'b0);
      add_item(8'h00, 1'b1, 1'b1, 1'b0);
      add_item(8'h00, 1'b1, 1'b0, 1'b0);
      add_item(8'h00, 1'b0, 1'b0, 1'b0);
      add_item(8'hff, 1'b0, 1'b1, 1'b1);
      add_item(8'h00, 1'b0, 1'b1, 1'b0);

      // random messages, lengths biased to the padding boundaries
      while (stim_items < 650) begin
         r = $urandom_range(0, 9);
         if (r < 3)
            len = $urandom_range(0, 8);
         else if (r < 6)
            case ($urandom_range(0, 9))
               0: len = 55;
               1: len = 56;
               2: len = 57;
               3: len = 63;
               4: len = 64;
               5: len = 65;
               6: len = 119;
               7: len = 120;
               8: len = 127;
               default: len = 128;
            endcase
         else
            len = $urandom_range(1, 70);
         add_message(len, $urandom_range(0, 7) == 0);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_tvalid || digest_queue.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("[md5_message_digest_unit] OK");
      else
         $display("[md5_message_digest_unit] ERROR");
      $finish;
   end

endmodule
